// ===== hw/rtl/line_sensor_tracker_assert.svh =====
// assertion helpers shared by the tracker rtl
// both are clocked on aclk and held off while aresetn is low
`ifndef LINE_SENSOR_TRACKER_ASSERT_SVH
`define LINE_SENSOR_TRACKER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lst_pkg.sv =====
`timescale 1ns / 1ps

package lst_pkg;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    // run segments
    localparam logic [2:0] SEG_IDLE = 3'd0;
    localparam logic [2:0] SEG_AB   = 3'd1;
    localparam logic [2:0] SEG_BC   = 3'd2;
    localparam logic [2:0] SEG_CD   = 3'd3;
    localparam logic [2:0] SEG_DA   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_STEER_GAIN       = 2'd0;
    localparam logic [1:0] CFG_STRAIGHT_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_ARC_TIMEOUT      = 2'd2;

    // configuration reset values
    localparam logic [15:0] GAIN_RESET             = 16'd61;
    localparam logic [15:0] STRAIGHT_TIMEOUT_RESET = 16'd500;
    localparam logic [15:0] ARC_TIMEOUT_RESET      = 16'd800;

    // datapath sizes
    localparam int NUM_SENSORS = 7;
    localparam int MAG_W       = 13;
    localparam int HITS_W      = 3;
    localparam int DIV_STEPS   = MAG_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [MAG_W-1:0] ERR_LIMIT = 13'd3000;
    localparam logic [15:0]      TICK_MAX  = 16'hFFFF;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } lst_div_stat_t;

    // sensor weight (i-3)*10
    function automatic logic signed [7:0] sensor_weight(input logic [2:0] idx);
        logic signed [7:0] w;
        case (idx)
            3'd0:    w = -8'sd30;
            3'd1:    w = -8'sd20;
            3'd2:    w = -8'sd10;
            3'd3:    w = 8'sd0;
            3'd4:    w = 8'sd10;
            3'd5:    w = 8'sd20;
            3'd6:    w = 8'sd30;
            default: w = 8'sd0;
        endcase
        return w;
    endfunction

    // saturating 16-bit increment
    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == TICK_MAX) ? TICK_MAX : v + 16'd1;
    endfunction

endpackage

// ===== hw/rtl/lst_div.sv =====
`timescale 1ns / 1ps

module lst_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [lst_pkg::MAG_W-1:0]    dividend,
    input  logic [lst_pkg::HITS_W-1:0]   divisor,
    output logic [lst_pkg::MAG_W-1:0]    quotient,
    output lst_pkg::lst_div_stat_t       stat
);

    logic [lst_pkg::MAG_W-1:0]     dvd_reg;
    logic [lst_pkg::HITS_W-1:0]    rem_reg;
    logic [lst_pkg::HITS_W-1:0]    dsr_reg;
    logic [lst_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [lst_pkg::HITS_W:0]      rem_shift;
    logic                          q_bit;
    logic [lst_pkg::HITS_W:0]      rem_sub;
    logic [lst_pkg::HITS_W-1:0]    rem_next;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[lst_pkg::MAG_W-1]};
        rem_sub   = rem_shift - {1'b0, dsr_reg};
        q_bit     = (rem_shift >= {1'b0, dsr_reg});
        rem_next  = q_bit ? rem_sub[lst_pkg::HITS_W-1:0] : rem_shift[lst_pkg::HITS_W-1:0];
    end

    // step counter and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= lst_pkg::DIV_CNT_W'(lst_pkg::DIV_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == lst_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and quotient shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[lst_pkg::MAG_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hw/rtl/line_sensor_tracker.sv =====
`timescale 1ns / 1ps

// Line sensor tracker: turns seven line-sensor hits into a clamped line error
// (weighted position x100, truncated toward zero), runs straight/arc tick
// timers, a four-segment lap sequencer and a Q4.12 steering target. One
// request is taken at a time. A sensor tick runs through the bit-serial
// divider, one quotient bit per cycle over 13 bits, then the quotient
// hand-over, the state update, the multiply for the steering target, the
// output load and the return to idle that takes the next transfer; set and
// reset requests skip the divider and start at the state update. The load
// waits while the previous result is still unaccepted, which holds off the
// next transfer. Configuration writes are taken at any time and are meant
// to happen only while no request is in flight.
module line_sensor_tracker (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [6:0]         s_sensor_bits,
    input  logic [2:0]         s_new_segment,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [12:0] m_line_error,
    output logic [2:0]         m_hit_count,
    output logic               m_on_arc,
    output logic [2:0]         m_segment,
    output logic [15:0]        m_laps_done,
    output logic signed [16:0] m_steer_target,
    output logic [15:0]        m_straight_ticks,
    output logic [15:0]        m_arc_ticks,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

`include "line_sensor_tracker_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_STEER,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   out_load;

    // configuration
    logic [15:0] gain_reg;
    logic [15:0] straight_to_reg;
    logic [15:0] arc_to_reg;

    // tracker state
    logic signed [12:0] err_reg;
    logic [2:0]         hits_reg;
    logic               arc_reg;
    logic [2:0]         seg_reg;
    logic [15:0]        seg_ticks_reg;
    logic [15:0]        laps_reg;
    logic [15:0]        straight_reg;
    logic [15:0]        arc_run_reg;

    // request held across the work
    logic [1:0]         req_reg;
    logic [2:0]         new_seg_reg;
    logic [2:0]         pend_hits_reg;
    logic               neg_reg;
    logic signed [29:0] prod_reg;

    // output registers
    logic               m_valid_reg;
    logic signed [12:0] m_err_reg;
    logic [2:0]         m_hits_reg;
    logic               m_arc_reg;
    logic [2:0]         m_seg_reg;
    logic [15:0]        m_laps_reg;
    logic signed [16:0] m_steer_reg;
    logic [15:0]        m_straight_reg;
    logic [15:0]        m_arc_ticks_reg;

    // front end of a tick
    logic signed [7:0]  wsum;
    logic [2:0]         in_hits;
    logic signed [13:0] num;
    logic [12:0]        mag;
    logic               accept;
    logic               div_start;

    logic [12:0]                quotient;
    lst_pkg::lst_div_stat_t     div_stat;

    // next tracker state
    logic [12:0]        q_clamp;
    logic signed [12:0] err_next;
    logic [2:0]         hits_next;
    logic               arc_next;
    logic [2:0]         seg_next;
    logic [15:0]        seg_ticks_next;
    logic [15:0]        laps_next;
    logic [15:0]        straight_next;
    logic [15:0]        arc_run_next;
    logic [15:0]        st_inc;
    logic signed [29:0] prod_next;

    logic               err_in_range;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign div_start = accept && (s_req_type == lst_pkg::REQ_TICK);
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // weighted sum and hit count of the sensor bits
    always_comb begin
        wsum    = '0;
        in_hits = '0;
        for (int i = 0; i < lst_pkg::NUM_SENSORS; i++) begin
            if (s_sensor_bits[i]) begin
                wsum    = wsum + lst_pkg::sensor_weight(3'(i));
                in_hits = in_hits + 3'd1;
            end
        end
        num = 14'(wsum) * 14'sd100;
        mag = num[13] ? 13'(-num) : 13'(num);
    end

    lst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag),
        .divisor  (in_hits),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // state update for the held request
    always_comb begin
        err_next       = err_reg;
        hits_next      = hits_reg;
        arc_next       = arc_reg;
        seg_next       = seg_reg;
        seg_ticks_next = seg_ticks_reg;
        laps_next      = laps_reg;
        straight_next  = straight_reg;
        arc_run_next   = arc_run_reg;
        q_clamp        = (quotient > lst_pkg::ERR_LIMIT) ? lst_pkg::ERR_LIMIT : quotient;
        st_inc         = lst_pkg::sat_inc16(seg_ticks_reg);
        case (req_reg)
            lst_pkg::REQ_TICK: begin
                hits_next = pend_hits_reg;
                arc_next  = (pend_hits_reg != 3'd0);
                if (pend_hits_reg == 3'd0) begin
                    err_next = '0;
                end else begin
                    err_next = neg_reg ? -$signed(q_clamp) : $signed(q_clamp);
                end
                if (arc_next) begin
                    straight_next = '0;
                    arc_run_next  = lst_pkg::sat_inc16(arc_run_reg);
                end else begin
                    straight_next = lst_pkg::sat_inc16(straight_reg);
                    arc_run_next  = '0;
                end
                // lap sequencer
                if (seg_reg != lst_pkg::SEG_IDLE) begin
                    seg_ticks_next = st_inc;
                end
                case (seg_reg)
                    lst_pkg::SEG_AB, lst_pkg::SEG_CD: begin
                        if (arc_next || st_inc > straight_to_reg) begin
                            seg_next       = seg_reg + 3'd1;
                            seg_ticks_next = '0;
                        end
                    end
                    lst_pkg::SEG_BC: begin
                        if (!arc_next || st_inc > arc_to_reg) begin
                            seg_next       = lst_pkg::SEG_CD;
                            seg_ticks_next = '0;
                        end
                    end
                    lst_pkg::SEG_DA: begin
                        if (!arc_next || st_inc > arc_to_reg) begin
                            seg_next       = lst_pkg::SEG_IDLE;
                            laps_next      = laps_reg + 16'd1;
                            seg_ticks_next = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            lst_pkg::REQ_SET: begin
                if (new_seg_reg <= lst_pkg::SEG_DA) begin
                    seg_next = new_seg_reg;
                end
            end
            lst_pkg::REQ_RESET: begin
                seg_next      = lst_pkg::SEG_IDLE;
                straight_next = '0;
                arc_run_next  = '0;
            end
            default: begin
            end
        endcase
    end

    // steering product from the kept error and current gain
    assign prod_next = 30'(err_reg) * 30'($signed({1'b0, gain_reg}));

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg        <= lst_pkg::GAIN_RESET;
            straight_to_reg <= lst_pkg::STRAIGHT_TIMEOUT_RESET;
            arc_to_reg      <= lst_pkg::ARC_TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lst_pkg::CFG_STEER_GAIN:       gain_reg        <= cfg_data;
                lst_pkg::CFG_STRAIGHT_TIMEOUT: straight_to_reg <= cfg_data;
                lst_pkg::CFG_ARC_TIMEOUT:      arc_to_reg      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer, tracker state and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            err_reg       <= '0;
            hits_reg      <= '0;
            arc_reg       <= 1'b0;
            seg_reg       <= lst_pkg::SEG_IDLE;
            seg_ticks_reg <= '0;
            laps_reg      <= '0;
            straight_reg  <= '0;
            arc_run_reg   <= '0;
        end else begin
            // output valid: set on load, cleared on transfer
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        req_reg       <= s_req_type;
                        new_seg_reg   <= s_new_segment;
                        pend_hits_reg <= in_hits;
                        neg_reg       <= num[13];
                        state_reg     <= (s_req_type == lst_pkg::REQ_TICK) ? ST_DIV : ST_UPD;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    err_reg       <= err_next;
                    hits_reg      <= hits_next;
                    arc_reg       <= arc_next;
                    seg_reg       <= seg_next;
                    seg_ticks_reg <= seg_ticks_next;
                    laps_reg      <= laps_next;
                    straight_reg  <= straight_next;
                    arc_run_reg   <= arc_run_next;
                    state_reg     <= ST_STEER;
                end
                ST_STEER: begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // load the result once the output register is free
                    if (out_load) begin
                        m_err_reg       <= err_reg;
                        m_hits_reg      <= hits_reg;
                        m_arc_reg       <= arc_reg;
                        m_seg_reg       <= seg_reg;
                        m_laps_reg      <= laps_reg;
                        m_steer_reg     <= arc_reg ? prod_reg[28:12] : '0;
                        m_straight_reg  <= straight_reg;
                        m_arc_ticks_reg <= arc_run_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_line_error     = m_err_reg;
    assign m_hit_count      = m_hits_reg;
    assign m_on_arc         = m_arc_reg;
    assign m_segment        = m_seg_reg;
    assign m_laps_done      = m_laps_reg;
    assign m_steer_target   = m_steer_reg;
    assign m_straight_ticks = m_straight_reg;
    assign m_arc_ticks      = m_arc_ticks_reg;

    // error stays within the clamp
    assign err_in_range = (m_err_reg <= $signed({1'b0, lst_pkg::ERR_LIMIT})) &&
                          (m_err_reg >= -$signed({1'b0, lst_pkg::ERR_LIMIT}));

    // checks
    `LST_ASSERT_NEXT(a_tick_starts_div, div_start, div_stat.busy, "tick did not start divider")
    `LST_ASSERT_NOW(a_no_accept_busy, div_stat.busy, !s_ready, "ready while dividing")
    `LST_ASSERT_NOW(a_err_range, m_valid, err_in_range, "line error out of range")
    `LST_ASSERT_NOW(a_steer_off_arc, m_valid && !m_on_arc, m_steer_target == '0, "steer off arc")
    `LST_ASSERT_NOW(a_arc_hits, m_valid, m_on_arc == (m_hit_count != 3'd0), "arc flag vs hits")

endmodule
